// File: sv/rat_pkg.sv
// ----------------------------------------------------------------------------
// rat_pkg: shared types and codes for the rational accumulator ALU
// Operation and status codes, channel payloads, controller/datapath links.
// ----------------------------------------------------------------------------
package rat_pkg;

    localparam logic [2:0] OP_LOAD = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] operand_numerator;
        logic signed [31:0] operand_denominator;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_numerator;
        logic [30:0]        result_denominator;
        logic [1:0]         status;
    } out_item_t;

    // controller -> datapath commands
    typedef struct packed {
        logic capture;   // latch input item
        logic norm_op;   // normalize operand sign, start operand gcd
        logic gcd_step;  // one gcd iteration
        logic div_start; // start exact division by gcd
        logic div_step;  // one restoring division bit
        logic apply_op;  // form wide products / sums
        logic commit;    // check range and update accumulator
        logic reduce_res;// 0: reducing operand, 1: reducing result
    } cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic valid_op;
        logic zero_den_in;
        logic num_zero;
        logic gcd_done;
        logic div_done;
        logic nq_zero;
    } sts_t;

endpackage

// File: sv/rational_accumulator_alu_top.sv
// ----------------------------------------------------------------------------
// rational_accumulator_alu_top: rational accumulator ALU
// Keeps one reduced signed fraction and applies load/add/sub/mul/div to it.
// ----------------------------------------------------------------------------
// One item is processed at a time. Each transfer in produces exactly one
// transfer out carrying the accumulator after the step and a status code
// (ok, zero denominator, overflow); on an error the accumulator is kept.
// The processing time depends on the shared binary gcd unit, run on the
// 32-bit operand and on the 64-bit result terms, and on the bit-serial
// exact divider; both are used once for the operand and once for the
// result. A zero operand numerator skips the operand reduction and a
// zero result numerator skips the result one. An unknown operation or a
// zero denominator goes from the operand check straight to the commit.
// The result sits in its own register, so the next item is taken as soon
// as the block is idle; its commit waits until the previous result has
// been transferred.
module rational_accumulator_alu_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rat_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rat_pkg::out_item_t m_data
);
    rat_pkg::cmd_t cmd;
    rat_pkg::sts_t sts;

    rat_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd)
    );

    rat_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_item(s_data), .cmd(cmd),
        .sts(sts), .m_item(m_data)
    );
endmodule

// File: sv/rat_ctrl.sv
// ----------------------------------------------------------------------------
// rat_ctrl: sequencing controller
// Steps the datapath through operand reduction, operation and result reduction.
// ----------------------------------------------------------------------------
module rat_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  rat_pkg::sts_t sts,
    output rat_pkg::cmd_t cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_OGCD, S_ODIV, S_APPLY, S_RCHK, S_RGCD, S_RDIV,
        S_COMMIT
    } state_t;

    state_t state_reg;
    logic   out_full_reg;
    logic   out_full_next;

    // a held result only blocks the commit, not the input
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_full_reg;

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:   cmd.capture = s_valid && s_ready;
            S_CHECK:  cmd.norm_op = 1'b1;
            S_OGCD:   cmd.gcd_step = 1'b1;
            S_ODIV:   cmd.div_step = 1'b1;
            S_APPLY:  cmd.apply_op = 1'b1;
            S_RCHK:   cmd.reduce_res = 1'b1;
            S_RGCD:   begin cmd.gcd_step = 1'b1; cmd.reduce_res = 1'b1; end
            S_RDIV:   begin cmd.div_step = 1'b1; cmd.reduce_res = 1'b1; end
            S_COMMIT: cmd.commit = !out_full_reg || m_ready;
            default:  cmd = '0;
        endcase
        if ((state_reg == S_OGCD || state_reg == S_RGCD) && sts.gcd_done)
            cmd.div_start = 1'b1;
    end

    always_comb begin
        priority if (cmd.commit) out_full_next = 1'b1;
        else if (out_full_reg && m_ready) out_full_next = 1'b0;
        else out_full_next = out_full_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            out_full_reg <= 1'b0;
        end else begin
            out_full_reg <= out_full_next;
            unique case (state_reg)
                S_IDLE: if (s_valid && s_ready) state_reg <= S_CHECK;
                S_CHECK: begin
                    if (!sts.valid_op || sts.zero_den_in) state_reg <= S_COMMIT;
                    else if (sts.num_zero) state_reg <= S_APPLY;
                    else state_reg <= S_OGCD;
                end
                S_OGCD: if (sts.gcd_done) state_reg <= S_ODIV;
                S_ODIV: if (sts.div_done) state_reg <= S_APPLY;
                S_APPLY: state_reg <= S_RCHK;
                S_RCHK: begin
                    if (sts.nq_zero || sts.num_zero) state_reg <= S_COMMIT;
                    else state_reg <= S_RGCD;
                end
                S_RGCD: if (sts.gcd_done) state_reg <= S_RDIV;
                S_RDIV: if (sts.div_done) state_reg <= S_COMMIT;
                S_COMMIT: if (cmd.commit) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: sv/rat_dp.sv
// ----------------------------------------------------------------------------
// rat_dp: rational datapath
// Accumulator, wide products, binary gcd and bit-serial exact division.
// ----------------------------------------------------------------------------
module rat_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  rat_pkg::in_item_t   s_item,
    input  rat_pkg::cmd_t       cmd,
    output rat_pkg::sts_t       sts,
    output rat_pkg::out_item_t  m_item
);
    localparam int W = 64;

    logic [2:0]         op_reg;
    logic signed [31:0] ip_reg, iq_reg;
    logic signed [31:0] acc_p_reg;
    logic [30:0]        acc_q_reg;
    // working fraction: sign plus magnitudes
    logic               neg_reg;
    logic [W-1:0]       mp_reg, mq_reg;
    // operand after normalization
    logic               on_reg;
    logic [32:0]        op_p_reg, op_q_reg;
    // gcd (binary) registers
    logic [W-1:0]       ga_reg, gb_reg;
    logic [6:0]         gk_reg;
    logic               gdone_reg;
    // division
    logic [W-1:0]       g_reg, quo_p_reg, quo_q_reg, rem_p_reg, rem_q_reg;
    logic [6:0]         dcnt_reg;
    logic               dact_reg;
    // products: up to three 33x33 multiplies, all formed in the apply cycle
    logic [1:0]         status_reg;
    logic [1:0]         stat_pend_reg;
    // result register, parts the output from the accumulator
    logic signed [31:0] out_p_reg;
    logic [30:0]        out_q_reg;

    logic valid_op;
    assign valid_op = (op_reg <= rat_pkg::OP_DIV);

    assign sts.valid_op    = valid_op;
    assign sts.zero_den_in = (iq_reg == 32'sd0);
    // during the operand check the working regs are not loaded yet
    assign sts.num_zero    = cmd.norm_op ? (ip_reg == 32'sd0) : (mp_reg == '0);
    assign sts.gcd_done    = gdone_reg;
    assign sts.div_done    = dact_reg && (dcnt_reg == 7'd0);
    assign sts.nq_zero     = (mq_reg == '0);

    // signed wide values of accumulator and operand
    logic [32:0] a_pm, a_q;
    logic        a_n;
    assign a_n  = acc_p_reg[31];
    assign a_pm = a_n ? (33'd0 - {acc_p_reg[31], acc_p_reg})
                      : {1'b0, acc_p_reg};
    assign a_q  = {2'b00, acc_q_reg};

    logic [65:0] x1, x2; // magnitudes of the two cross terms
    logic [65:0] prod_q;
    logic        s1, s2;
    logic [W-1:0] ab1, ab2;
    always_comb begin
        x1 = '0; x2 = '0; s1 = 1'b0; s2 = 1'b0;
        unique case (op_reg)
            rat_pkg::OP_MUL: begin x1 = a_pm * op_p_reg; s1 = a_n ^ on_reg;
                prod_q = a_q * op_q_reg; end
            rat_pkg::OP_DIV: begin x1 = a_pm * op_q_reg; s1 = a_n ^ on_reg;
                prod_q = a_q * op_p_reg; end
            default: begin
                x1 = a_pm * op_q_reg; s1 = a_n;
                x2 = a_q * op_p_reg;  s2 = on_reg ^ (op_reg == rat_pkg::OP_SUB);
                prod_q = a_q * op_q_reg;
            end
        endcase
        ab1 = x1[W-1:0];
        ab2 = x2[W-1:0];
    end

    logic [W:0] diff12, diff21;
    assign diff12 = {1'b0, ab1} - {1'b0, ab2};
    assign diff21 = {1'b0, ab2} - {1'b0, ab1};

    // binary gcd step helper and trial subtractions of the exact divider
    logic [W-1:0] gd;
    assign gd = (ga_reg > gb_reg) ? (ga_reg - gb_reg) : (gb_reg - ga_reg);

    logic [W:0] tp, tq;
    assign tp = {rem_p_reg[W-1:0], quo_p_reg[W-1]} - {1'b0, g_reg};
    assign tq = {rem_q_reg[W-1:0], quo_q_reg[W-1]} - {1'b0, g_reg};

    logic [W-1:0] mp_chk;
    assign mp_chk = mp_reg;

    // range check and signed numerator of the reduced result
    logic               ovf;
    logic signed [31:0] new_p;
    assign ovf   = (mp_chk > (neg_reg ? 64'h8000_0000 : 64'h7FFF_FFFF)) ||
                   (mq_reg > 64'h7FFF_FFFF);
    assign new_p = neg_reg ? (32'd0 - mp_reg[31:0]) : mp_reg[31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_p_reg  <= '0;
            acc_q_reg  <= 31'd1;
            out_p_reg  <= '0;
            out_q_reg  <= 31'd1;
            gdone_reg  <= 1'b0;
            dact_reg   <= 1'b0;
            status_reg <= rat_pkg::ST_OK;
        end else begin
            if (cmd.capture) begin
                op_reg <= s_item.operation;
                ip_reg <= s_item.operand_numerator;
                iq_reg <= s_item.operand_denominator;
                stat_pend_reg <= rat_pkg::ST_OK;
            end
            if (cmd.norm_op) begin
                // sign to numerator: sign = sign(p) xor sign(q)
                neg_reg <= ip_reg[31] ^ iq_reg[31];
                mp_reg <= {32'd0, (ip_reg[31] ? (32'd0 - ip_reg) : ip_reg)};
                mq_reg <= {32'd0, (iq_reg[31] ? (32'd0 - iq_reg) : iq_reg)};
                if (!valid_op) stat_pend_reg <= rat_pkg::ST_OK;
                else if (iq_reg == 32'sd0) stat_pend_reg <= rat_pkg::ST_ZERO_DEN;
                ga_reg <= {32'd0, (ip_reg[31] ? (32'd0 - ip_reg) : ip_reg)};
                gb_reg <= {32'd0, (iq_reg[31] ? (32'd0 - iq_reg) : iq_reg)};
                gk_reg <= '0;
                gdone_reg <= 1'b0;
                // zero numerator operand skips reduction: preset operand
                on_reg   <= 1'b0;
                op_p_reg <= '0;
                op_q_reg <= {1'b0, (iq_reg[31] ? (32'd0 - iq_reg) : iq_reg)};
            end
            if (cmd.reduce_res && !cmd.gcd_step && !cmd.div_step && !cmd.div_start) begin
                ga_reg <= mp_reg;
                gb_reg <= mq_reg;
                gk_reg <= '0;
                gdone_reg <= 1'b0;
                if (mq_reg == '0) stat_pend_reg <= rat_pkg::ST_ZERO_DEN;
            end
            if (cmd.gcd_step && !gdone_reg) begin
                priority if (ga_reg == gb_reg) gdone_reg <= 1'b1;
                else if (!ga_reg[0] && !gb_reg[0]) begin
                    ga_reg <= ga_reg >> 1; gb_reg <= gb_reg >> 1;
                    gk_reg <= gk_reg + 7'd1;
                end else if (!ga_reg[0]) ga_reg <= ga_reg >> 1;
                else if (!gb_reg[0]) gb_reg <= gb_reg >> 1;
                else if (ga_reg > gb_reg) ga_reg <= gd >> 1;
                else gb_reg <= gd >> 1;
            end
            if (cmd.div_start) begin
                g_reg     <= ga_reg << gk_reg[5:0];
                quo_p_reg <= mp_reg;
                quo_q_reg <= mq_reg;
                rem_p_reg <= '0;
                rem_q_reg <= '0;
                dcnt_reg  <= 7'd64;
                dact_reg  <= 1'b1;
                gdone_reg <= 1'b0;
            end
            if (cmd.div_step && dact_reg) begin
                if (dcnt_reg == 7'd0) begin
                    dact_reg <= 1'b0;
                    mp_reg <= quo_p_reg;
                    mq_reg <= quo_q_reg;
                    if (!cmd.reduce_res) begin
                        op_p_reg <= quo_p_reg[32:0];
                        op_q_reg <= quo_q_reg[32:0];
                        on_reg   <= neg_reg;
                    end
                end else begin
                    dcnt_reg <= dcnt_reg - 7'd1;
                    if (!tp[W]) begin
                        rem_p_reg <= tp[W-1:0];
                        quo_p_reg <= {quo_p_reg[W-2:0], 1'b1};
                    end else begin
                        rem_p_reg <= {rem_p_reg[W-2:0], quo_p_reg[W-1]};
                        quo_p_reg <= {quo_p_reg[W-2:0], 1'b0};
                    end
                    if (!tq[W]) begin
                        rem_q_reg <= tq[W-1:0];
                        quo_q_reg <= {quo_q_reg[W-2:0], 1'b1};
                    end else begin
                        rem_q_reg <= {rem_q_reg[W-2:0], quo_q_reg[W-1]};
                        quo_q_reg <= {quo_q_reg[W-2:0], 1'b0};
                    end
                end
            end
            if (cmd.apply_op) begin
                unique case (op_reg)
                    rat_pkg::OP_LOAD: begin
                        neg_reg <= on_reg && (op_p_reg != '0);
                        mp_reg <= {31'd0, op_p_reg};
                        mq_reg <= {31'd0, op_q_reg};
                    end
                    rat_pkg::OP_MUL, rat_pkg::OP_DIV: begin
                        neg_reg <= s1 && (ab1 != '0);
                        mp_reg <= ab1;
                        mq_reg <= prod_q[W-1:0];
                    end
                    default: begin
                        mq_reg <= prod_q[W-1:0];
                        if (s1 == s2) begin
                            mp_reg <= ab1 + ab2;
                            neg_reg <= s1 && ((ab1 + ab2) != '0);
                        end else if (!diff12[W]) begin
                            mp_reg <= diff12[W-1:0];
                            neg_reg <= s1 && (diff12[W-1:0] != '0);
                        end else begin
                            mp_reg <= diff21[W-1:0];
                            neg_reg <= s2;
                        end
                    end
                endcase
            end
            if (cmd.commit) begin
                if (!valid_op) begin
                    status_reg <= rat_pkg::ST_OK;
                    out_p_reg  <= acc_p_reg;
                    out_q_reg  <= acc_q_reg;
                end else if (stat_pend_reg != rat_pkg::ST_OK) begin
                    status_reg <= stat_pend_reg;
                    out_p_reg  <= acc_p_reg;
                    out_q_reg  <= acc_q_reg;
                end else if (ovf) begin
                    status_reg <= rat_pkg::ST_OVERFLOW;
                    out_p_reg  <= acc_p_reg;
                    out_q_reg  <= acc_q_reg;
                end else begin
                    status_reg <= rat_pkg::ST_OK;
                    acc_p_reg  <= new_p;
                    acc_q_reg  <= mq_reg[30:0];
                    out_p_reg  <= new_p;
                    out_q_reg  <= mq_reg[30:0];
                end
            end
        end
    end

    assign m_item.result_numerator   = out_p_reg;
    assign m_item.result_denominator = out_q_reg;
    assign m_item.status             = status_reg;
endmodule
